FILE: src/tsac_pkg.sv
// Shared types, widths and register codes for the touch sensor anomaly checker.
package tsac_pkg;

   localparam int SENSOR_W    = 5;
   localparam int COUNT_W     = 16;
   localparam int MULT_W      = 4;
   localparam int HYST_W      = 8;
   localparam int MASK_W      = 32;
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 48;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   localparam logic [MULT_W-1:0]  HYPER_MULT_RESET  = 4'd3;
   localparam logic [COUNT_W-1:0] NML_LIMIT_RESET   = 16'd100;
   localparam logic [COUNT_W-1:0] STUCK_LIMIT_RESET = 16'd1000;
   localparam logic               BASELINE_EN_RESET = 1'b1;

   typedef enum logic [1:0] {
      REG_HYPER_MULT,
      REG_NML_LIMIT,
      REG_STUCK_LIMIT,
      REG_BASELINE_EN
   } csr_reg_type;

   typedef struct packed {
      logic                pad;
      logic [HYST_W-1:0]   hysteresis_value;
      logic [COUNT_W-1:0]  noise_threshold;
      logic [COUNT_W-1:0]  finger_threshold;
      logic                touch_active;
      logic [COUNT_W-1:0]  diff_count;
      logic                check_enable;
      logic [SENSOR_W-1:0] sensor_index;
   } req_item_type;

   typedef struct packed {
      logic [5:0]          pad;
      logic [MASK_W-1:0]   anomaly_mask;
      logic                baseline_reset_request;
      logic                anomaly;
      logic                stuck_hit;
      logic                no_mans_land_hit;
      logic                hyper_event;
      logic [SENSOR_W-1:0] result_sensor;
   } rsp_item_type;

   typedef struct packed {
      logic                bump;
      logic [SENSOR_W-1:0] sensor;
   } cnt_req_type;

endpackage

FILE: src/tsac_counter_bank.sv
// Per-sensor limit counters that clear on a hit, with read-modify-write on commit.
module tsac_counter_bank #(
   parameter int NUM_SENSORS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          commit,
   input  tsac_pkg::cnt_req_type         req,
   input  logic [tsac_pkg::COUNT_W-1:0]  limit,
   output logic                          hit
);

   localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

   logic [tsac_pkg::COUNT_W-1:0] count_ff [NUM_SENSORS];
   logic [tsac_pkg::COUNT_W-1:0] count_in [NUM_SENSORS];
   logic [IDX_W-1:0]             idx;
   logic [tsac_pkg::COUNT_W:0]   next_count;

   assign idx        = req.sensor[IDX_W-1:0];
   assign next_count = (tsac_pkg::COUNT_W + 1)'(count_ff[idx]) + (tsac_pkg::COUNT_W + 1)'(1);
   assign hit        = req.bump && (next_count > (tsac_pkg::COUNT_W + 1)'(limit));

   always_comb begin
      count_in = count_ff;
      if (commit && req.bump) begin
         if (hit) begin
            count_in[idx] = '0;
         end else begin
            count_in[idx] = next_count[tsac_pkg::COUNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SENSORS; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

FILE: src/touch_sensor_anomaly_check.sv
// Top level of the touch sensor anomaly checker: input stage, checks and result register.
//
// Channel  Dir  Handshake          Payload
// req      in   req_tvalid/tready  tdata: scan result fields, tuser: first_of_scan
// rsp      out  rsp_tvalid/tready  tdata: causes, flags and running anomaly mask
// csr      in   APB psel/penable   four configuration registers at 0x0, 0x4, 0x8, 0xC
//
// An accepted word is held in the input stage and moves into the result register when that
// register is free or being taken; one word is taken every cycle while the result is not stalled.
// The per-sensor counters are updated as a word moves into the result register, so the
// next word for the same sensor sees the new count without a stall.
// Reset clears all counters, the anomaly mask and the configuration to its defaults.
// A stalled result holds the input stage, which in turn holds req_tready low.
module touch_sensor_anomaly_check #(
   parameter int NUM_SENSORS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // sensor_index, check_enable, diff_count, touch_active, finger_threshold,
   // noise_threshold, hysteresis_value, zero fill
   input  logic [tsac_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // first_of_scan
   input  logic [0:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // result_sensor, hyper_event, no_mans_land_hit, stuck_hit, anomaly,
   // baseline_reset_request, anomaly_mask, zero fill
   output logic [tsac_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tsac_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [tsac_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [tsac_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int PROD_W = tsac_pkg::MULT_W + tsac_pkg::COUNT_W;
   localparam int SUM_W  = tsac_pkg::COUNT_W + 1;

   logic [tsac_pkg::MULT_W-1:0]  hyper_mult_ff,  hyper_mult_in;
   logic [tsac_pkg::COUNT_W-1:0] nml_limit_ff,   nml_limit_in;
   logic [tsac_pkg::COUNT_W-1:0] stuck_limit_ff, stuck_limit_in;
   logic                         baseline_en_ff, baseline_en_in;

   logic                         s1_valid_ff, s1_valid_in;
   tsac_pkg::req_item_type       s1_item_ff,  s1_item_in;
   logic                         s1_first_ff, s1_first_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   tsac_pkg::rsp_item_type       rsp_item_ff,  rsp_item_in;
   logic [tsac_pkg::MASK_W-1:0]  scan_mask_ff, scan_mask_in;

   logic                         csr_write;
   tsac_pkg::csr_reg_type        csr_reg;
   logic                         advance;
   logic                         accept_in;
   logic                         check_on;
   logic [PROD_W-1:0]            hyper_level;
   logic                         hyper;
   logic                         in_band;
   tsac_pkg::cnt_req_type        band_req, touch_req;
   logic                         band_hit, stuck_hit;
   logic                         anomaly;
   logic [tsac_pkg::MASK_W-1:0]  mask_base;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = tsac_pkg::csr_reg_type'(csr_paddr[3:2]);

   always_comb begin
      csr_prdata = '0;
      unique case (csr_reg)
         tsac_pkg::REG_HYPER_MULT:  csr_prdata = tsac_pkg::CSR_DATA_W'(hyper_mult_ff);
         tsac_pkg::REG_NML_LIMIT:   csr_prdata = tsac_pkg::CSR_DATA_W'(nml_limit_ff);
         tsac_pkg::REG_STUCK_LIMIT: csr_prdata = tsac_pkg::CSR_DATA_W'(stuck_limit_ff);
         tsac_pkg::REG_BASELINE_EN: csr_prdata = tsac_pkg::CSR_DATA_W'(baseline_en_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   always_comb begin
      hyper_mult_in  = hyper_mult_ff;
      nml_limit_in   = nml_limit_ff;
      stuck_limit_in = stuck_limit_ff;
      baseline_en_in = baseline_en_ff;
      if (csr_write) begin
         unique case (csr_reg)
            tsac_pkg::REG_HYPER_MULT:  hyper_mult_in  = csr_pwdata[tsac_pkg::MULT_W-1:0];
            tsac_pkg::REG_NML_LIMIT:   nml_limit_in   = csr_pwdata[tsac_pkg::COUNT_W-1:0];
            tsac_pkg::REG_STUCK_LIMIT: stuck_limit_in = csr_pwdata[tsac_pkg::COUNT_W-1:0];
            tsac_pkg::REG_BASELINE_EN: baseline_en_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept_in  = req_tvalid && req_tready;

   assign check_on = s1_item_ff.check_enable &&
                     ((tsac_pkg::SENSOR_W + 1)'(s1_item_ff.sensor_index) <
                      (tsac_pkg::SENSOR_W + 1)'(NUM_SENSORS));

   assign hyper_level = PROD_W'(hyper_mult_ff) * PROD_W'(s1_item_ff.finger_threshold);
   assign hyper       = check_on && (PROD_W'(s1_item_ff.diff_count) > hyper_level);
   assign in_band     = (s1_item_ff.diff_count > s1_item_ff.noise_threshold) &&
                        (SUM_W'(s1_item_ff.diff_count) <
                         SUM_W'(s1_item_ff.finger_threshold) +
                         SUM_W'(s1_item_ff.hysteresis_value));

   assign band_req.bump    = check_on && in_band;
   assign band_req.sensor  = s1_item_ff.sensor_index;
   assign touch_req.bump   = check_on && s1_item_ff.touch_active;
   assign touch_req.sensor = s1_item_ff.sensor_index;

   tsac_counter_bank #(
      .NUM_SENSORS (NUM_SENSORS)
   ) u_band_bank (
      .clock  (clock),
      .reset  (reset),
      .commit (advance),
      .req    (band_req),
      .limit  (nml_limit_ff),
      .hit    (band_hit)
   );

   tsac_counter_bank #(
      .NUM_SENSORS (NUM_SENSORS)
   ) u_touch_bank (
      .clock  (clock),
      .reset  (reset),
      .commit (advance),
      .req    (touch_req),
      .limit  (stuck_limit_ff),
      .hit    (stuck_hit)
   );

   assign anomaly   = hyper || band_hit || stuck_hit;
   assign mask_base = s1_first_ff ? '0 : scan_mask_ff;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_item_in   = s1_item_ff;
      s1_first_in  = s1_first_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      scan_mask_in = scan_mask_ff;

      if (advance) begin
         scan_mask_in = anomaly ?
                        (mask_base | (tsac_pkg::MASK_W'(1) << s1_item_ff.sensor_index)) :
                        mask_base;
         rsp_item_in.pad                    = '0;
         rsp_item_in.anomaly_mask           = scan_mask_in;
         rsp_item_in.baseline_reset_request = anomaly && baseline_en_ff;
         rsp_item_in.anomaly                = anomaly;
         rsp_item_in.stuck_hit              = stuck_hit;
         rsp_item_in.no_mans_land_hit       = band_hit;
         rsp_item_in.hyper_event            = hyper;
         rsp_item_in.result_sensor          = s1_item_ff.sensor_index;
         rsp_valid_in                       = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept_in) begin
         s1_item_in  = tsac_pkg::req_item_type'(req_tdata);
         s1_first_in = req_tuser[0];
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hyper_mult_ff  <= tsac_pkg::HYPER_MULT_RESET;
         nml_limit_ff   <= tsac_pkg::NML_LIMIT_RESET;
         stuck_limit_ff <= tsac_pkg::STUCK_LIMIT_RESET;
         baseline_en_ff <= tsac_pkg::BASELINE_EN_RESET;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         scan_mask_ff   <= '0;
      end else begin
         hyper_mult_ff  <= hyper_mult_in;
         nml_limit_ff   <= nml_limit_in;
         stuck_limit_ff <= stuck_limit_in;
         baseline_en_ff <= baseline_en_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         scan_mask_ff   <= scan_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      s1_first_ff <= s1_first_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_item_ff;

endmodule

FILE: src/tsac_checker.sv
// Port-level assertions for the touch sensor anomaly checker and their binding.
module tsac_port_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [tsac_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   tsac_pkg::rsp_item_type rsp_item;

   assign rsp_item = rsp_tdata;

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled result word changed or was dropped.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_item.anomaly ==
                     (rsp_item.hyper_event || rsp_item.no_mans_land_hit || rsp_item.stuck_hit))
      else $error("Anomaly flag does not match its causes.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_item.baseline_reset_request |-> rsp_item.anomaly)
      else $error("Baseline reset requested without an anomaly.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_item.anomaly |->
         ((rsp_item.anomaly_mask >> rsp_item.result_sensor) & tsac_pkg::MASK_W'(1)) != '0)
      else $error("Anomalous sensor missing from the anomaly mask.");

   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("Result valid right after reset.");

endmodule

bind touch_sensor_anomaly_check tsac_port_checker u_tsac_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
